### hw/rtl/bgi_pkg.sv
`timescale 1ns / 1ps
package bgi_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int XA = $clog2(MAX_X_POINTS);
  localparam int YA = $clog2(MAX_Y_POINTS);
  localparam int KW = (XA > YA) ? XA : YA;
  localparam int CW = KW + 1;
  localparam int GD = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GA = $clog2(GD);

  typedef enum logic [1:0] {
    OP_WR_X  = 2'd0,
    OP_WR_Y  = 2'd1,
    OP_WR_G  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  localparam logic [1:0] CFG_FILL = 2'd0;
  localparam logic [1:0] CFG_XPTS = 2'd1;
  localparam logic [1:0] CFG_YPTS = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_DEG  = 2'd3;

  localparam int DIV_STEPS = 64;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic {
    AX_X = 1'b0,
    AX_Y = 1'b1
  } axis_t;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_RES  = 2'd1,
    DST_ROW0 = 2'd2,
    DST_ROW1 = 2'd3
  } dst_t;

  typedef enum logic [1:0] {
    SRC_GRID = 2'd0,
    SRC_SEG  = 2'd1,
    SRC_FILL = 2'd2
  } src_t;

  typedef struct packed {
    logic  wr;
    logic  load_q;
    logic  lat_first;
    logic  lat_last;
    logic  prev_ld;
    axis_t ax;
    logic  ld_lo;
    logic  ld_hi;
    logic  use_rows;
    logic  mul;
    logic  div_step;
    dst_t  dst;
    src_t  src;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic ex;
    logic ey;
    logic q_first;
    logic q_last;
    logic hit;
  } sts_t;

  function automatic logic in_seg(input logic signed [31:0] q,
                                  input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input logic rising);
    return rising ? (q >= a && q <= b) : (q <= a && q >= b);
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

endpackage

### hw/rtl/bgi_datapath.sv
`timescale 1ns / 1ps
module bgi_datapath import bgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [31:0] in_write_data,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  cmd_t               cmd,
  input  logic [KW-1:0]      x_idx,
  input  logic [KW-1:0]      y_idx,
  input  logic [KW-1:0]      g_row,
  input  logic [KW-1:0]      g_col,
  output sts_t               sts,
  output logic [CW-1:0]      nx,
  output logic [CW-1:0]      ny,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  logic signed [31:0] xmem [MAX_X_POINTS];
  logic signed [31:0] ymem [MAX_Y_POINTS];
  logic signed [31:0] gmem [GD];

  logic signed [31:0] x_rd_r, y_rd_r, g_rd_r;
  logic signed [31:0] fill_r;
  logic [6:0]         xcnt_r, ycnt_r;
  logic signed [31:0] qx_r, qy_r, xf_r, xl_r, yf_r, yl_r, prev_r;
  logic signed [31:0] a0_r, a1_r, v0_r, v1_r, row0_r, row1_r, res_r;
  logic [63:0]        p_r;
  logic [31:0]        rem_r, d_r;
  logic               neg_r, dz_r, fill_flag_r, sat_r, deg_r;

  logic [31:0] wcol32, wrow32, gw32, gr32, xc32, yc32, nx32, ny32;
  logic        x_we, y_we, g_we;
  logic        rx, ry, rise_sel;
  logic signed [31:0] q_sel, first_sel, last_sel, ard;
  logic signed [32:0] dq, dv, da;
  logic [32:0]        t;
  logic               t_ge;
  logic [32:0]        t_sub;
  logic signed [36:0] v0e, qe, sum37;
  logic               big, ovf, seg_sat;
  logic signed [31:0] seg_val, dval;

  assign wcol32 = {26'd0, in_col_index};
  assign wrow32 = {26'd0, in_row_index};
  assign x_we = cmd.wr && in_op == OP_WR_X && wcol32 < 32'(MAX_X_POINTS);
  assign y_we = cmd.wr && in_op == OP_WR_Y && wrow32 < 32'(MAX_Y_POINTS);
  assign g_we = cmd.wr && in_op == OP_WR_G && wcol32 < 32'(MAX_X_POINTS)
                && wrow32 < 32'(MAX_Y_POINTS);
  assign gw32 = wrow32 * 32'(MAX_X_POINTS) + wcol32;
  assign gr32 = 32'(g_row) * 32'(MAX_X_POINTS) + 32'(g_col);

  always_ff @(posedge clk) begin
    if (x_we) xmem[wcol32[XA-1:0]] <= in_write_data;
    x_rd_r <= xmem[x_idx[XA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (y_we) ymem[wrow32[YA-1:0]] <= in_write_data;
    y_rd_r <= ymem[y_idx[YA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[gw32[GA-1:0]] <= in_write_data;
    g_rd_r <= gmem[gr32[GA-1:0]];
  end

  // clamp point counts into 2..MAX
  assign xc32 = {25'd0, xcnt_r};
  assign yc32 = {25'd0, ycnt_r};
  assign nx32 = (xc32 < 32'd2) ? 32'd2 :
                (xc32 > 32'(MAX_X_POINTS)) ? 32'(MAX_X_POINTS) : xc32;
  assign ny32 = (yc32 < 32'd2) ? 32'd2 :
                (yc32 > 32'(MAX_Y_POINTS)) ? 32'(MAX_Y_POINTS) : yc32;
  assign nx = nx32[CW-1:0];
  assign ny = ny32[CW-1:0];

  assign rx = xl_r > xf_r;
  assign ry = yl_r > yf_r;
  assign q_sel     = (cmd.ax == AX_Y) ? qy_r : qx_r;
  assign first_sel = (cmd.ax == AX_Y) ? yf_r : xf_r;
  assign last_sel  = (cmd.ax == AX_Y) ? yl_r : xl_r;
  assign rise_sel  = (cmd.ax == AX_Y) ? ry : rx;
  assign ard       = (cmd.ax == AX_Y) ? y_rd_r : x_rd_r;

  always_comb begin
    sts.outside = !in_seg(qx_r, xf_r, xl_r, rx) || !in_seg(qy_r, yf_r, yl_r, ry);
    sts.ex      = qx_r == xl_r;
    sts.ey      = qy_r == yl_r;
    sts.q_first = q_sel == first_sel;
    sts.q_last  = q_sel == last_sel;
    sts.hit     = in_seg(q_sel, prev_r, ard, rise_sel);
  end

  assign dq = {q_sel[31], q_sel} - {a0_r[31], a0_r};
  assign dv = {v1_r[31], v1_r} - {v0_r[31], v0_r};
  assign da = {a1_r[31], a1_r} - {a0_r[31], a0_r};

  // one restoring divide step per cycle; quotient shifts into p_r
  assign t     = {rem_r, p_r[63]};
  assign t_ge  = t >= {1'b0, d_r};
  assign t_sub = t - {1'b0, d_r};

  assign v0e   = 37'(v0_r);
  assign qe    = $signed({2'b00, p_r[34:0]});
  assign sum37 = neg_r ? (v0e - qe) : (v0e + qe);
  assign big   = (|p_r[63:35]) || (p_r[34] && (|p_r[33:0]));
  assign ovf   = sum37[36:31] != {6{sum37[31]}};
  assign seg_sat = !dz_r && (big || ovf);

  always_comb begin
    if (dz_r) begin
      seg_val = v0_r;
    end else if (big) begin
      seg_val = neg_r ? Q_MIN : Q_MAX;
    end else if (ovf) begin
      seg_val = sum37[36] ? Q_MIN : Q_MAX;
    end else begin
      seg_val = sum37[31:0];
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_GRID: dval = g_rd_r;
      SRC_SEG:  dval = seg_val;
      SRC_FILL: dval = fill_r;
      default:  dval = g_rd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      xcnt_r      <= 7'd64;
      ycnt_r      <= 7'd64;
      fill_flag_r <= 1'b0;
      sat_r       <= 1'b0;
      deg_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FILL: fill_r <= cfg_data;
          CFG_XPTS: xcnt_r <= cfg_data[6:0];
          CFG_YPTS: ycnt_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.load_q) begin
        fill_flag_r <= 1'b0;
        sat_r       <= 1'b0;
        deg_r       <= 1'b0;
      end else if (cmd.dst != DST_NONE) begin
        if (cmd.src == SRC_FILL) fill_flag_r <= 1'b1;
        if (cmd.src == SRC_SEG) begin
          if (dz_r) deg_r <= 1'b1;
          if (seg_sat) sat_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      qx_r <= in_query_x;
      qy_r <= in_query_y;
    end
    if (cmd.lat_first) begin
      xf_r <= x_rd_r;
      yf_r <= y_rd_r;
    end
    if (cmd.lat_last) begin
      xl_r <= x_rd_r;
      yl_r <= y_rd_r;
    end
    if (cmd.prev_ld) prev_r <= ard;
    if (cmd.ld_lo) begin
      a0_r <= ard;
      v0_r <= cmd.use_rows ? row0_r : g_rd_r;
    end
    if (cmd.ld_hi) begin
      a1_r <= ard;
      v1_r <= cmd.use_rows ? row1_r : g_rd_r;
    end
    if (cmd.mul) begin
      p_r   <= 64'(mag33(dq)) * 64'(mag33(dv));
      d_r   <= mag33(da);
      rem_r <= '0;
      neg_r <= (dq[32] ^ dv[32]) ^ da[32];
      dz_r  <= da == '0;
    end else if (cmd.div_step) begin
      rem_r <= t_ge ? t_sub[31:0] : t[31:0];
      p_r   <= {p_r[62:0], t_ge};
    end
    case (cmd.dst)
      DST_RES:  res_r  <= dval;
      DST_ROW0: row0_r <= dval;
      DST_ROW1: row1_r <= dval;
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_result_value <= res_r;
      out_status <= fill_flag_r ? ST_FILL : deg_r ? ST_DEG : sat_r ? ST_SAT : ST_OK;
    end
  end

endmodule

### hw/rtl/bgi_ctrl.sv
`timescale 1ns / 1ps
module bgi_ctrl import bgi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  output logic          out_valid,
  input  logic          out_ready,
  input  sts_t          sts,
  input  logic [CW-1:0] nx,
  input  logic [CW-1:0] ny,
  output cmd_t          cmd,
  output logic [KW-1:0] x_idx,
  output logic [KW-1:0] y_idx,
  output logic [KW-1:0] g_row,
  output logic [KW-1:0] g_col
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_LAT_LAST, S_DECIDE, S_CORNER, S_AX_START,
    S_SRCH0, S_SRCH1, S_SRCH2, S_LD0, S_LD1, S_LD2, S_MUL, S_DIV, S_SEG,
    S_GRAB, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    J_EDGE, J_FIND, J_ROW0, J_ROW1, J_YSEG
  } job_t;

  state_t        state_r, state_nxt;
  job_t          job_r, job_nxt;
  axis_t         ax_r, ax_nxt;
  logic [KW-1:0] k_r, k_nxt, r_r, r_nxt, fix_r, fix_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [KW-1:0] aidx;
  logic [CW-1:0] n_sel, nxm1, nym1, nsm1, kp1, kp2, rp1;
  logic          deliver;
  logic [KW-1:0] kfound;
  logic          found;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  assign n_sel = (ax_r == AX_Y) ? ny : nx;
  assign nxm1  = nx - CW'(1);
  assign nym1  = ny - CW'(1);
  assign nsm1  = n_sel - CW'(1);
  assign kp1   = CW'(k_r) + CW'(1);
  assign kp2   = CW'(k_r) + CW'(2);
  assign rp1   = CW'(r_r) + CW'(1);

  assign x_idx = (state_r == S_RD_LAST) ? nxm1[KW-1:0] : aidx;
  assign y_idx = (state_r == S_RD_LAST) ? nym1[KW-1:0] : aidx;
  assign g_row = (ax_r == AX_X) ? fix_r : aidx;
  assign g_col = (ax_r == AX_X) ? aidx : fix_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    ax_nxt    = ax_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    fix_nxt   = fix_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.ax    = ax_r;
    cmd.use_rows = job_r == J_YSEG;
    aidx      = k_r;
    deliver   = 1'b0;
    found     = 1'b0;
    kfound    = k_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.load_q = 1'b1;
            state_nxt  = S_RD_FIRST;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD_FIRST: begin
        aidx      = '0;
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.lat_first = 1'b1;
        state_nxt     = S_LAT_LAST;
      end
      S_LAT_LAST: begin
        cmd.lat_last = 1'b1;
        state_nxt    = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.outside) begin
          cmd.src   = SRC_FILL;
          cmd.dst   = DST_RES;
          state_nxt = S_FINISH;
        end else if (sts.ex && sts.ey) begin
          job_nxt   = J_EDGE;
          ax_nxt    = AX_X;
          fix_nxt   = nym1[KW-1:0];
          state_nxt = S_CORNER;
        end else if (sts.ey) begin
          job_nxt   = J_EDGE;
          ax_nxt    = AX_X;
          fix_nxt   = nym1[KW-1:0];
          state_nxt = S_AX_START;
        end else if (sts.ex) begin
          job_nxt   = J_EDGE;
          ax_nxt    = AX_Y;
          fix_nxt   = nxm1[KW-1:0];
          state_nxt = S_AX_START;
        end else begin
          job_nxt   = J_FIND;
          ax_nxt    = AX_Y;
          state_nxt = S_SRCH0;
        end
      end
      S_CORNER: begin
        aidx      = nxm1[KW-1:0];
        state_nxt = S_GRAB;
      end
      S_AX_START: begin
        if (sts.q_first) begin
          aidx      = '0;
          state_nxt = S_GRAB;
        end else if (sts.q_last) begin
          aidx      = nsm1[KW-1:0];
          state_nxt = S_GRAB;
        end else begin
          state_nxt = S_SRCH0;
        end
      end
      S_SRCH0: begin
        aidx      = '0;
        state_nxt = S_SRCH1;
      end
      S_SRCH1: begin
        cmd.prev_ld = 1'b1;
        aidx        = KW'(1);
        k_nxt       = '0;
        state_nxt   = S_SRCH2;
      end
      S_SRCH2: begin
        // no enclosing segment falls back to the first one
        if (sts.hit) begin
          found  = 1'b1;
          kfound = k_r;
        end else if (kp2 == n_sel) begin
          found  = 1'b1;
          kfound = '0;
        end else begin
          cmd.prev_ld = 1'b1;
          aidx        = kp2[KW-1:0];
          k_nxt       = kp1[KW-1:0];
        end
        if (found) begin
          if (job_r == J_FIND) begin
            r_nxt     = kfound;
            fix_nxt   = kfound;
            job_nxt   = J_ROW0;
            ax_nxt    = AX_X;
            state_nxt = S_AX_START;
          end else begin
            k_nxt     = kfound;
            state_nxt = S_LD0;
          end
        end
      end
      S_LD0: begin
        aidx      = k_r;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        cmd.ld_lo = 1'b1;
        aidx      = kp1[KW-1:0];
        state_nxt = S_LD2;
      end
      S_LD2: begin
        cmd.ld_hi = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.src = SRC_SEG;
        deliver = 1'b1;
      end
      S_GRAB: begin
        cmd.src = SRC_GRID;
        deliver = 1'b1;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (deliver) begin
      case (job_r)
        J_ROW0: begin
          cmd.dst   = DST_ROW0;
          job_nxt   = J_ROW1;
          fix_nxt   = rp1[KW-1:0];
          state_nxt = S_AX_START;
        end
        J_ROW1: begin
          cmd.dst   = DST_ROW1;
          job_nxt   = J_YSEG;
          ax_nxt    = AX_Y;
          k_nxt     = r_r;
          state_nxt = S_LD0;
        end
        default: begin
          cmd.dst   = DST_RES;
          state_nxt = S_FINISH;
        end
      endcase
    end

    if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_EDGE;
      ax_r        <= AX_X;
      k_r         <= '0;
      r_r         <= '0;
      fix_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      ax_r        <= ax_nxt;
      k_r         <= k_nxt;
      r_r         <= r_nxt;
      fix_r       <= fix_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
// channel  ports                                               dir
// cfg      cfg_valid cfg_ready cfg_index cfg_data              in (ready tied high)
// in       in_valid in_ready in_op in_row_index in_col_index
//          in_write_data in_query_x in_query_y                 in
// out      out_valid out_ready out_result_value out_status     out
//
// Writes are stored as they are accepted and give no item. A query first reads
// the axis ends and decides, then each axis interpolation runs a segment search
// and then load, multiply and a one-bit-per-cycle divide; an interior query
// does a y search and three interpolations. Reset (rst_n low at an edge) resets
// control and config; the stores hold nothing until written. A finished result
// waits in the output register; a later query holds in its last cycle until that
// result is taken, and no new item is accepted meanwhile.
module bilinear_grid_interpolator import bgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [31:0] in_write_data,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  cmd_t          cmd;
  sts_t          sts;
  logic [KW-1:0] x_idx, y_idx, g_row, g_col;
  logic [CW-1:0] nx, ny;

  assign cfg_ready = 1'b1;

  bgi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .nx       (nx),
    .ny       (ny),
    .cmd      (cmd),
    .x_idx    (x_idx),
    .y_idx    (y_idx),
    .g_row    (g_row),
    .g_col    (g_col)
  );

  bgi_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_write_data   (in_write_data),
    .in_query_x      (in_query_x),
    .in_query_y      (in_query_y),
    .cmd             (cmd),
    .x_idx           (x_idx),
    .y_idx           (y_idx),
    .g_row           (g_row),
    .g_col           (g_col),
    .sts             (sts),
    .nx              (nx),
    .ny              (ny),
    .out_result_value(out_result_value),
    .out_status      (out_status)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb import bgi_pkg::*;;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam int LIMIT = 6000000;
  localparam int RAND_ITEMS = 1750;

  typedef struct {
    logic signed [31:0] val;
    logic [1:0]         st;
  } result_t;

  // Tracks the stores and registers and works out the result of each query.
  class interp_scoreboard;
    int xs[64];
    int ys[64];
    int grid[4096];
    int fill;
    int unsigned xpts;
    int unsigned ypts;
    bit sat_hit;
    bit deg_hit;
    result_t due[$];
    int errors;
    int checked;
    int status_seen[4];

    function new();
      fill = 0;
      xpts = 64;
      ypts = 64;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        CFG_FILL: fill = d;
        CFG_XPTS: xpts = d[6:0];
        CFG_YPTS: ypts = d[6:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > QHI) begin
        sat_hit = 1;
        return QHI;
      end
      if (v < QLO) begin
        sat_hit = 1;
        return QLO;
      end
      return v;
    endfunction

    function bit [63:0] magn(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint lerp1(longint q, longint a0, longint a1, longint v0, longint v1);
      longint dq;
      longint dv;
      longint da;
      bit neg;
      bit [63:0] quot;
      dq = q - a0;
      dv = v1 - v0;
      da = a1 - a0;
      if (da == 0) begin
        deg_hit = 1;
        return v0;
      end
      neg = ((dq < 0) != (dv < 0)) != (da < 0);
      quot = (magn(dq) * magn(dv)) / magn(da);
      if (quot > 64'd17179869184) begin
        sat_hit = 1;
        return neg ? QLO : QHI;
      end
      return clip(neg ? v0 - longint'(quot) : v0 + longint'(quot));
    endfunction

    function bit enclosed(longint q, longint a, longint b, bit up);
      return up ? (q >= a && q <= b) : (q <= a && q >= b);
    endfunction

    function longint point(bit on_y, int k);
      return on_y ? ys[k] : xs[k];
    endfunction

    function longint val(bit on_y, int line, int k);
      return on_y ? grid[k * 64 + line] : grid[line * 64 + k];
    endfunction

    function int seek(bit on_y, int n, bit up, longint q);
      for (int k = 0; k + 1 < n; k++)
        if (enclosed(q, point(on_y, k), point(on_y, k + 1), up)) return k;
      return 0;
    endfunction

    function longint along(bit on_y, int n, bit up, longint q, int line);
      int k;
      if (q == point(on_y, 0)) return val(on_y, line, 0);
      if (q == point(on_y, n - 1)) return val(on_y, line, n - 1);
      k = seek(on_y, n, up, q);
      return lerp1(q, point(on_y, k), point(on_y, k + 1),
                   val(on_y, line, k), val(on_y, line, k + 1));
    endfunction

    function int span(int unsigned n);
      return n < 2 ? 2 : (n > 64 ? 64 : n);
    endfunction

    function result_t predict(longint qx, longint qy);
      int nx;
      int ny;
      int r;
      bit rx;
      bit ry;
      longint res;
      longint v0;
      longint v1;
      result_t o;
      sat_hit = 0;
      deg_hit = 0;
      nx = span(xpts);
      ny = span(ypts);
      rx = xs[nx - 1] > xs[0];
      ry = ys[ny - 1] > ys[0];
      if (!enclosed(qx, xs[0], xs[nx - 1], rx) || !enclosed(qy, ys[0], ys[ny - 1], ry)) begin
        o.val = fill;
        o.st = ST_FILL;
        return o;
      end
      if (qx == xs[nx - 1] && qy == ys[ny - 1]) res = grid[(ny - 1) * 64 + nx - 1];
      else if (qy == ys[ny - 1]) res = along(0, nx, rx, qx, ny - 1);
      else if (qx == xs[nx - 1]) res = along(1, ny, ry, qy, nx - 1);
      else begin
        r = seek(1, ny, ry, qy);
        v0 = along(0, nx, rx, qx, r);
        v1 = along(0, nx, rx, qx, r + 1);
        res = lerp1(qy, ys[r], ys[r + 1], v0, v1);
      end
      res = clip(res);
      o.val = res[31:0];
      o.st = deg_hit ? ST_DEG : (sat_hit ? ST_SAT : ST_OK);
      return o;
    endfunction

    function void note_item(op_t op, int row, int col, int wd, int qx, int qy);
      case (op)
        OP_WR_X: xs[col] = wd;
        OP_WR_Y: ys[row] = wd;
        OP_WR_G: grid[row * 64 + col] = wd;
        OP_QUERY: due.push_back(predict(qx, qy));
      endcase
    endfunction

    function void check(logic signed [31:0] v, logic [1:0] st);
      result_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: value %0d status %0d", v, st);
        return;
      end
      e = due.pop_front();
      checked++;
      status_seen[e.st]++;
      if (v !== e.val || st !== e.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: value %0d/%0d status %0d/%0d (exp/got)",
                   checked, e.val, v, e.st, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_op;
  logic [5:0] in_row_index;
  logic [5:0] in_col_index;
  logic signed [31:0] in_write_data;
  logic signed [31:0] in_query_x;
  logic signed [31:0] in_query_y;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;

  interp_scoreboard sb;
  bit quiet;
  bit hold_out;
  bit pressed;
  int rand_items;
  int cycles;

  bilinear_grid_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_write_data(in_write_data), .in_query_x(in_query_x), .in_query_y(in_query_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_status(out_status)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check(out_result_value, out_status);

  // Receiver: mostly ready, short and long stalls, one very long hold-off.
  initial begin
    int r;
    out_ready <= 0;
    wait (rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_out) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end else if (quiet || r < 65) begin
        out_ready <= 1;
        @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(20, 400)) @(posedge clk);
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  task automatic send(op_t op, int row, int col, int wd, int qx, int qy);
    int g;
    in_valid <= 1;
    in_op <= op;
    in_row_index <= row[5:0];
    in_col_index <= col[5:0];
    in_write_data <= wd;
    in_query_x <= qx;
    in_query_y <= qy;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, row[5:0], col[5:0], wd, qx, qy);
    rand_items++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic query(int qx, int qy);
    send(OP_QUERY, $urandom, $urandom, $urandom, qx, qy);
  endtask

  task automatic put(op_t op, int row, int col, int wd);
    send(op, row, col, wd, $urandom, $urandom);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Drain pending queries; writes leave no result, so allow a few more cycles.
  task automatic settle();
    in_valid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return int'(QHI);
    if (r == 1) return int'(QLO);
    if (r < 6) return $urandom;
    return $urandom_range(0, 1 << 21) - (1 << 20);
  endfunction

  function int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(2, 8);
    if (r < 80) return $urandom_range(9, 20);
    if (r < 84) return 64;
    if (r < 90) return $urandom_range(0, 1);
    if (r < 95) return $urandom_range(65, 127);
    return $urandom_range(21, 63);
  endfunction

  // Mostly in range or on an entry; some just outside, some anywhere.
  function int pick_coord(bit on_y, int n);
    int r;
    int k;
    longint a;
    longint b;
    longint lo;
    longint hi;
    bit [63:0] rnd;
    r = $urandom_range(0, 99);
    rnd = {$urandom, $urandom};
    a = sb.point(on_y, 0);
    b = sb.point(on_y, n - 1);
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    if (r < 25) return int'(sb.point(on_y, $urandom_range(0, n - 1)));
    if (r < 75) begin
      k = $urandom_range(0, n - 2);
      a = sb.point(on_y, k);
      b = sb.point(on_y, k + 1);
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return int'(lo + longint'(rnd % (hi - lo + 1)));
    end
    if (r < 85) return int'(hi + 1 + $urandom_range(0, 1000));
    if (r < 90) return int'(lo - 1 - $urandom_range(0, 1000));
    if (r < 96) return $urandom;
    return $urandom_range(0, 1) ? int'(QHI) : int'(QLO);
  endfunction

  task automatic build_axis(bit on_y, int n, int style);
    longint v;
    longint step;
    int dir;
    op_t op;
    op = on_y ? OP_WR_Y : OP_WR_X;
    dir = (style % 2) ? -1 : 1;
    v = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
    for (int k = 0; k < n; k++) begin
      case (style)
        4: v = QLO + (longint'(k) * 64'sd4294967295) / (n - 1);
        5: v = QHI - (longint'(k) * 64'sd4294967295) / (n - 1);
        6: v = int'($urandom);
        default: begin
          step = $urandom_range(1, 1 << 18);
          if (style >= 2 && $urandom_range(0, 3) == 0) step = 0;
          if (k > 0) v = v + dir * step;
        end
      endcase
      put(op, k, k, int'(v));
    end
  endtask

  initial begin
    int nx;
    int ny;
    int nq;
    int op;
    sb = new();
    rst_n <= 0;
    cfg_valid <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    in_valid <= 0;
    in_op <= 0;
    in_row_index <= 0;
    in_col_index <= 0;
    in_write_data <= 0;
    in_query_x <= 0;
    in_query_y <= 0;
    quiet = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    quiet = 0;
    settle();

    // Directed: falling y axis with a zero-length first segment.
    write_reg(CFG_FILL, QHI);
    write_reg(CFG_XPTS, 32'hFFFF_FF83);
    write_reg(CFG_YPTS, 32'h0000_0003);
    put(OP_WR_X, 0, 0, 0);
    put(OP_WR_X, 0, 1, 2 << 16);
    put(OP_WR_X, 0, 2, 4 << 16);
    put(OP_WR_Y, 0, 0, 5 << 16);
    put(OP_WR_Y, 1, 0, 5 << 16);
    put(OP_WR_Y, 2, 0, -(5 << 16));
    put(OP_WR_G, 0, 0, QHI);
    put(OP_WR_G, 0, 1, QLO);
    put(OP_WR_G, 0, 2, 7);
    put(OP_WR_G, 1, 0, 0);
    put(OP_WR_G, 1, 1, 100 << 16);
    put(OP_WR_G, 1, 2, -3);
    put(OP_WR_G, 2, 0, -(1 << 16));
    put(OP_WR_G, 2, 1, QHI);
    put(OP_WR_G, 2, 2, 12345);
    settle();
    write_reg(CFG_XPTS, 3);
    query(1 << 16, 5 << 16);
    query(4 << 16, -(5 << 16));
    query(3 << 16, -(5 << 16));
    query(4 << 16, 0);
    query(0, 0);
    query(QLO, 0);
    query(1 << 16, QHI);
    query(3 << 16, 1 << 16);

    rand_items = 0;
    pressed = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      quiet = ($urandom_range(0, 4) == 0);
      write_reg(CFG_XPTS, {$urandom} & 32'hFFFF_FF80 | pick_count());
      write_reg(CFG_YPTS, {$urandom} & 32'hFFFF_FF80 | pick_count());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_FILL, pick_value());
      nx = sb.span(sb.xpts);
      ny = sb.span(sb.ypts);
      build_axis(0, nx, $urandom_range(0, 6));
      build_axis(1, ny, $urandom_range(0, 6));
      for (int r = 0; r < ny; r++)
        for (int c = 0; c < nx; c++) put(OP_WR_G, r, c, pick_value());
      // Hold off the receiver once while queries keep coming.
      if (!pressed) begin
        hold_out = 1;
        pressed = 1;
      end
      nq = $urandom_range(10, 40);
      for (int i = 0; i < nq; i++) begin
        // Stray writes break the axes now and then.
        if ($urandom_range(0, 9) == 0) begin
          op = $urandom_range(0, 2);
          put(op_t'(op), $urandom, $urandom, $urandom);
        end else begin
          query(pick_coord(0, nx), pick_coord(1, ny));
        end
      end
    end

    settle();
    repeat (500) @(posedge clk);
    if (sb.due.size() != 0) sb.errors++;
    $display("checked %0d query results: %0d ok, %0d filled, %0d saturated, %0d degenerate",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FILL],
             sb.status_seen[ST_SAT], sb.status_seen[ST_DEG]);
    $display("%0d mismatches over mixed axis shapes, point counts and fill values",
             sb.errors);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
